/* hdl/lidar_point_project_colorize_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lidar projection core
// Clocked, reset-gated assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_PROJECT_COLORIZE_CORE_DEFINES_SVH
`define LIDAR_POINT_PROJECT_COLORIZE_CORE_DEFINES_SVH

// same-cycle implication
`define LPPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lppc_pkg.sv */
// ----------------------------------------------------------------------------
// lppc_pkg
// Types and constants of the lidar point projection and colorize core.
// ----------------------------------------------------------------------------
package lppc_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int PT_W      = 24;
	localparam int COEF_W    = 32;
	localparam int PROD_W    = COEF_W + PT_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int DW        = PROD_W;     // divider operand width
	localparam int QW        = 12;         // widest quotient
	localparam int QW_JET    = 8;
	localparam int POINT_FRAC_BITS = 8;
	localparam int NUM_PROJ  = 6;
	localparam int TERMS     = 12;

	localparam logic [PT_W-1:0] RANGE_MIN_RESET = PT_W'(8388607);

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_MEASURE = 2'd1;
	localparam logic [1:0] ACT_PROJECT = 2'd2;

	localparam logic [1:0] STS_VISIBLE = 2'd0;
	localparam logic [1:0] STS_BEHIND  = 2'd1;
	localparam logic [1:0] STS_DEPTH   = 2'd2;
	localparam logic [1:0] STS_OFF     = 2'd3;

	localparam logic [2:0] CFG_WIDTH  = 3'd6;
	localparam logic [2:0] CFG_HEIGHT = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DRAIN, ST_CHK, ST_DIVU, ST_DIVV, ST_JET, ST_DIVJ, ST_FIN
	} state_t;

	typedef struct packed {
		logic          done;
		logic          ovf;
		logic [QW-1:0] quot;
	} div_res_t;

endpackage

/* hdl/lppc_div.sv */
// ----------------------------------------------------------------------------
// lppc_div
// Restoring divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module lppc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       narrow,
	input  logic [lppc_pkg::DW-1:0]    num,
	input  logic [lppc_pkg::DW-1:0]    den,
	output lppc_pkg::div_res_t         res
);

	localparam int SW = lppc_pkg::DW + lppc_pkg::QW;

	logic [lppc_pkg::DW-1:0] rem_q;
	logic [SW-1:0]           dsh_q;
	logic [3:0]              cnt_q;
	logic                    busy_q, first_q, done_q, ovf_q;
	logic [lppc_pkg::QW-1:0] quot_q;
	logic                    ge;

	assign ge = {{lppc_pkg::QW{1'b0}}, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && !first_q && cnt_q == 4'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num;
			dsh_q   <= narrow ? (SW'(den) << lppc_pkg::QW_JET) : (SW'(den) << lppc_pkg::QW);
			cnt_q   <= narrow ? 4'(lppc_pkg::QW_JET) : 4'(lppc_pkg::QW);
			first_q <= 1'b1;
			quot_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q[lppc_pkg::DW-1:0];
			dsh_q <= dsh_q >> 1;
			if (first_q) begin
				ovf_q   <= ge;
				first_q <= 1'b0;
			end else begin
				quot_q <= {quot_q[lppc_pkg::QW-2:0], ge};
				cnt_q  <= cnt_q - 4'd1;
			end
		end
	end

	assign res = '{done: done_q, ovf: ovf_q, quot: quot_q};

endmodule

/* hdl/lidar_point_project_colorize_core.sv */
// ----------------------------------------------------------------------------
// lidar_point_project_colorize_core
// Lidar point to pixel projection with jet range coloring.
// ----------------------------------------------------------------------------
// Clear and measure words do not make the input busy. A project word keeps the
// input busy while twelve passes through one shared 32x24 multiplier build the
// three row sums and one restoring divider then yields u (13 steps), v (13 steps)
// and the color ratio (9 steps); a behind-sensor point skips both, and a
// non-positive depth skips the divider. The input is not ready while a project
// word is in work; a finished result waits in the output register without
// blocking acceptance of the next word, which holds in its final state until
// the register is free.
module lidar_point_project_colorize_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // point_x, point_y, point_z
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pixel_u, pixel_v, red, green, blue
	output logic [1:0]  m_tuser    // status
);

	localparam int PW = lppc_pkg::PT_W;
	localparam int AW = lppc_pkg::ACC_W;
	localparam int DW = lppc_pkg::DW;
	localparam logic signed [PW-1:0] RANGE_MIN_INIT = lppc_pkg::RANGE_MIN_RESET;

	lppc_pkg::state_t state_q, state_d;

	logic [63:0]                  proj_q [lppc_pkg::NUM_PROJ];
	logic [lppc_pkg::DIM_W-1:0]   width_q, height_q, wclamp, hclamp;
	logic signed [PW-1:0]         rmin_q, rmax_q, x_q, y_q, z_q;
	logic [3:0]                   cnt_q;
	logic signed [lppc_pkg::PROD_W-1:0] prod, prod_s1;
	logic [1:0]                   prow_s1;
	logic                         pv_s1;
	logic signed [AW-1:0]         acc_q [3];
	logic [1:0]                   status_q, seg_q;
	logic [11:0]                  u_q, v_q;
	logic [7:0]                   r_q, g_q, b_q;
	logic                         m_tvalid_q;
	logic [47:0]                  m_tdata_q;
	logic [1:0]                   m_tuser_q;

	logic                         acc_in, in_pos;
	logic signed [PW-1:0]         in_x;
	logic [1:0]                   mrow, mterm;
	logic [2:0]                   midx;
	logic signed [lppc_pkg::COEF_W-1:0] coef;
	logic signed [PW-1:0]         mopnd;

	logic                         div_start, div_narrow;
	logic [DW-1:0]                div_num, div_den, abs0, abs1;
	lppc_pkg::div_res_t           dres;
	logic                         u_bad, v_bad, span_zero, out_free;

	logic signed [PW-1:0]         xc;
	logic [PW-1:0]                span, offs, nsel;
	logic [PW+1:0]                t4, d1, d2, d3, d4;
	logic [1:0]                   seg;
	logic [31:0]                  num255;

	assign s_tready = (state_q == lppc_pkg::ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign in_x     = s_tdata[PW-1:0];
	assign in_pos   = !in_x[PW-1] && (in_x != '0);
	assign out_free = !m_tvalid_q || m_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lppc_pkg::NUM_PROJ; i++)
				proj_q[i] <= '0;
			width_q  <= lppc_pkg::DIM_W'(640);
			height_q <= lppc_pkg::DIM_W'(480);
		end else if (cfg_we) begin
			if (cfg_index < 3'(lppc_pkg::NUM_PROJ))
				proj_q[cfg_index] <= cfg_data;
			else if (cfg_index == lppc_pkg::CFG_WIDTH)
				width_q <= cfg_data[lppc_pkg::DIM_W-1:0];
			else if (cfg_index == lppc_pkg::CFG_HEIGHT)
				height_q <= cfg_data[lppc_pkg::DIM_W-1:0];
		end
	end

	assign wclamp = (width_q > lppc_pkg::DIM_W'(lppc_pkg::MAX_DIM))
		? lppc_pkg::DIM_W'(lppc_pkg::MAX_DIM) : width_q;
	assign hclamp = (height_q > lppc_pkg::DIM_W'(lppc_pkg::MAX_DIM))
		? lppc_pkg::DIM_W'(lppc_pkg::MAX_DIM) : height_q;

	// shared multiplier: term order x, y, z, offset per row
	assign mrow  = cnt_q[3:2];
	assign mterm = cnt_q[1:0];
	assign midx  = {mrow, 1'b0} + {2'b00, mterm[1]};
	assign coef  = mterm[0] ? proj_q[midx][63:32] : proj_q[midx][31:0];

	always_comb begin
		case (mterm)
			2'd0:    mopnd = x_q;
			2'd1:    mopnd = y_q;
			2'd2:    mopnd = z_q;
			default: mopnd = PW'(1) <<< lppc_pkg::POINT_FRAC_BITS;
		endcase
	end

	assign prod = coef * mopnd;

	// division operands
	assign abs0 = acc_q[0][AW-1] ? DW'(-acc_q[0]) : DW'(acc_q[0]);
	assign abs1 = acc_q[1][AW-1] ? DW'(-acc_q[1]) : DW'(acc_q[1]);

	assign u_bad = dres.ovf || (acc_q[0][AW-1] && dres.quot != '0)
		|| ({1'b0, dres.quot} >= wclamp);
	assign v_bad = dres.ovf || (acc_q[1][AW-1] && dres.quot != '0)
		|| ({1'b0, dres.quot} >= hclamp);

	// jet segment
	assign span_zero = (rmax_q <= rmin_q);
	assign xc   = (x_q < rmin_q) ? rmin_q : ((x_q > rmax_q) ? rmax_q : x_q);
	assign span = rmax_q - rmin_q;
	assign offs = xc - rmin_q;
	assign t4   = {offs, 2'b00};
	assign d1   = {2'b00, span};
	assign d2   = {1'b0, span, 1'b0};
	assign d3   = d1 + d2;
	assign d4   = {span, 2'b00};

	always_comb begin
		if (t4 < d1) begin
			seg = 2'd0;  nsel = t4[PW-1:0];
		end else if (t4 < d2) begin
			seg = 2'd1;  nsel = PW'(d2 - t4);
		end else if (t4 < d3) begin
			seg = 2'd2;  nsel = PW'(t4 - d2);
		end else begin
			seg = 2'd3;  nsel = PW'(d4 - t4);
		end
	end

	assign num255 = ({8'd0, nsel} << 8) - {8'd0, nsel};

	lppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.narrow (div_narrow),
		.num    (div_num),
		.den    (div_den),
		.res    (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lppc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		div_narrow = 1'b0;
		div_num    = abs0;
		div_den    = DW'(acc_q[2]);
		case (state_q)
			lppc_pkg::ST_IDLE: begin
				if (acc_in && s_tuser == lppc_pkg::ACT_PROJECT)
					state_d = in_pos ? lppc_pkg::ST_MUL : lppc_pkg::ST_FIN;
			end
			lppc_pkg::ST_MUL: begin
				if (cnt_q == 4'(lppc_pkg::TERMS - 1))
					state_d = lppc_pkg::ST_DRAIN;
			end
			lppc_pkg::ST_DRAIN: state_d = lppc_pkg::ST_CHK;
			lppc_pkg::ST_CHK: begin
				if (acc_q[2][AW-1] || acc_q[2] == '0) begin
					state_d = lppc_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = lppc_pkg::ST_DIVU;
				end
			end
			lppc_pkg::ST_DIVU: begin
				div_num = abs1;
				if (dres.done) begin
					if (u_bad) begin
						state_d = lppc_pkg::ST_FIN;
					end else begin
						div_start = 1'b1;
						state_d   = lppc_pkg::ST_DIVV;
					end
				end
			end
			lppc_pkg::ST_DIVV: begin
				if (dres.done)
					state_d = v_bad ? lppc_pkg::ST_FIN : lppc_pkg::ST_JET;
			end
			lppc_pkg::ST_JET: begin
				div_narrow = 1'b1;
				div_num    = DW'(num255);
				div_den    = DW'(span);
				if (span_zero) begin
					state_d = lppc_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = lppc_pkg::ST_DIVJ;
				end
			end
			lppc_pkg::ST_DIVJ: begin
				if (dres.done)
					state_d = lppc_pkg::ST_FIN;
			end
			lppc_pkg::ST_FIN: begin
				if (out_free)
					state_d = lppc_pkg::ST_IDLE;
			end
			default: state_d = lppc_pkg::ST_IDLE;
		endcase
	end

	// frame range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q <= RANGE_MIN_INIT;
			rmax_q <= '0;
		end else if (acc_in) begin
			if (s_tuser == lppc_pkg::ACT_CLEAR) begin
				rmin_q <= RANGE_MIN_INIT;
				rmax_q <= '0;
			end else if (s_tuser == lppc_pkg::ACT_MEASURE && in_pos) begin
				if (in_x < rmin_q) rmin_q <= in_x;
				if (in_x > rmax_q) rmax_q <= in_x;
			end
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_s1 <= 1'b0;
		else
			pv_s1 <= (state_q == lppc_pkg::ST_MUL);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		prow_s1 <= mrow;
		if (pv_s1)
			acc_q[prow_s1] <= acc_q[prow_s1] + AW'(prod_s1);
		case (state_q)
			lppc_pkg::ST_IDLE: begin
				x_q      <= s_tdata[PW-1:0];
				y_q      <= s_tdata[2*PW-1:PW];
				z_q      <= s_tdata[3*PW-1:2*PW];
				cnt_q    <= '0;
				status_q <= lppc_pkg::STS_BEHIND;
				for (int i = 0; i < 3; i++)
					acc_q[i] <= '0;
			end
			lppc_pkg::ST_MUL: cnt_q <= cnt_q + 4'd1;
			lppc_pkg::ST_CHK: status_q <= lppc_pkg::STS_DEPTH;
			lppc_pkg::ST_DIVU: begin
				status_q <= lppc_pkg::STS_OFF;
				if (dres.done) u_q <= dres.quot;
			end
			lppc_pkg::ST_DIVV: begin
				if (dres.done) begin
					v_q <= dres.quot;
					if (!v_bad) status_q <= lppc_pkg::STS_VISIBLE;
				end
			end
			lppc_pkg::ST_JET: begin
				seg_q <= seg;
				r_q   <= 8'd0;
				g_q   <= 8'd0;
				b_q   <= 8'd255;
			end
			lppc_pkg::ST_DIVJ: begin
				if (dres.done) begin
					case (seg_q)
						2'd0: begin
							r_q <= 8'd0;   g_q <= dres.quot[7:0]; b_q <= 8'd255;
						end
						2'd1: begin
							r_q <= 8'd0;   g_q <= 8'd255; b_q <= dres.quot[7:0];
						end
						2'd2: begin
							r_q <= dres.quot[7:0]; g_q <= 8'd255; b_q <= 8'd0;
						end
						default: begin
							r_q <= 8'd255; g_q <= dres.quot[7:0]; b_q <= 8'd0;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == lppc_pkg::ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lppc_pkg::ST_FIN && out_free) begin
			m_tuser_q <= status_q;
			m_tdata_q <= (status_q == lppc_pkg::STS_VISIBLE)
				? {b_q, g_q, r_q, v_q, u_q} : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hdl/lppc_chk.sv */
// ----------------------------------------------------------------------------
// lppc_chk
// Port-level checks of the lidar projection core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_point_project_colorize_core_defines.svh"

module lppc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result word stays offered
	`LPPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// a project word makes the input busy
	`LPPC_ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready && s_tuser == lppc_pkg::ACT_PROJECT, !s_tready, "ready after project word")

	// non-visible results carry no pixel or color
	`LPPC_ASSERT_NOW(a_zero, clk, arst_n, m_tvalid && m_tuser != lppc_pkg::STS_VISIBLE, m_tdata == '0, "non-visible result has data")

endmodule

bind lidar_point_project_colorize_core lppc_chk u_lppc_chk (.*);

/* tb/sv/lidar_point_project_colorize_core_tb.sv */
// ----------------------------------------------------------------------------
// lidar_point_project_colorize_core_tb
// Drives clear, measure and project words into the projection core under
// random stalls and checks each result word against an in-bench projection
// and jet colormap predictor.
// ----------------------------------------------------------------------------
module lidar_point_project_colorize_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  sts;
		logic [11:0] u;
		logic [11:0] v;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	// predictor state
	logic [63:0]        proj_m [6];
	longint             img_w, img_h;
	longint             rng_min, rng_max;
	pixel_t             pixel_q[$];
	int                 err_cnt;
	longint             cyc;
	bit                 calm;

	lidar_point_project_colorize_core dut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > 64'd3_000_000) begin
			$display("FAIL lidar_point_project_colorize_core");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		err_cnt++;
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cyc);
	endtask

	// result checker
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[31:24],
				m_tdata[39:32], m_tdata[47:40]};
			if (pixel_q.size() == 0) begin
				report("unexpected word", got, 0);
			end else begin
				want = pixel_q.pop_front();
				if (got.sts != want.sts) report("status", got.sts, want.sts);
				if (got.u != want.u) report("pixel_u", got.u, want.u);
				if (got.v != want.v) report("pixel_v", got.v, want.v);
				if (got.r != want.r) report("red", got.r, want.r);
				if (got.g != want.g) report("green", got.g, want.g);
				if (got.b != want.b) report("blue", got.b, want.b);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
	end

	function automatic longint row_sum(int row, longint x, longint y, longint z);
		longint cx, cy, cz, off;
		cx  = longint'(signed'(proj_m[2*row][31:0]));
		cy  = longint'(signed'(proj_m[2*row][63:32]));
		cz  = longint'(signed'(proj_m[2*row+1][31:0]));
		off = longint'(signed'(proj_m[2*row+1][63:32]));
		return cx*x + cy*y + cz*z + off*256;
	endfunction

	function automatic pixel_t predict_pixel(longint x, longint y, longint z);
		pixel_t p;
		longint a0, a1, a2, u, v, w, h, c, d, t4;
		p = '0;
		if (x <= 0) begin
			p.sts = lppc_pkg::STS_BEHIND;
			return p;
		end
		a0 = row_sum(0, x, y, z);
		a1 = row_sum(1, x, y, z);
		a2 = row_sum(2, x, y, z);
		if (a2 <= 0) begin
			p.sts = lppc_pkg::STS_DEPTH;
			return p;
		end
		u = a0 / a2;
		v = a1 / a2;
		w = (img_w > lppc_pkg::MAX_DIM) ? lppc_pkg::MAX_DIM : img_w;
		h = (img_h > lppc_pkg::MAX_DIM) ? lppc_pkg::MAX_DIM : img_h;
		if (u < 0 || u >= w || v < 0 || v >= h) begin
			p.sts = lppc_pkg::STS_OFF;
			return p;
		end
		p.sts = lppc_pkg::STS_VISIBLE;
		p.u = u[11:0];
		p.v = v[11:0];
		if (rng_max <= rng_min) begin
			p.b = 8'd255;
			return p;
		end
		c = x < rng_min ? rng_min : (x > rng_max ? rng_max : x);
		d = rng_max - rng_min;
		t4 = 4 * (c - rng_min);
		if (t4 < d) begin
			p.g = 8'(255*t4/d); p.b = 8'd255;
		end else if (t4 < 2*d) begin
			p.g = 8'd255; p.b = 8'(255*(2*d - t4)/d);
		end else if (t4 < 3*d) begin
			p.r = 8'(255*(t4 - 2*d)/d); p.g = 8'd255;
		end else begin
			p.r = 8'd255; p.g = 8'(255*(4*d - t4)/d);
		end
		return p;
	endfunction

	// one input word; the prediction is taken at acceptance
	task automatic send_point(input logic [1:0] act, input logic [23:0] x,
			input logic [23:0] y, input logic [23:0] z);
		longint sx, sy, sz;
		sx = longint'(signed'(x));
		sy = longint'(signed'(y));
		sz = longint'(signed'(z));
		while (!calm && $urandom_range(99) < 30) @(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (act)
			lppc_pkg::ACT_CLEAR: begin
				rng_min = lppc_pkg::RANGE_MIN_RESET;
				rng_max = 0;
			end
			lppc_pkg::ACT_MEASURE: begin
				if (sx > 0) begin
					if (sx < rng_min) rng_min = sx;
					if (sx > rng_max) rng_max = sx;
				end
			end
			lppc_pkg::ACT_PROJECT: pixel_q = {pixel_q, predict_pixel(sx, sy, sz)};
			default: ;
		endcase
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < 3'd6) proj_m[idx] = val;
		else if (idx == lppc_pkg::CFG_WIDTH) img_w = val[12:0];
		else img_h = val[12:0];
	endtask

	function automatic logic [63:0] q16_pair(int lo, int hi);
		return {32'(hi), 32'(lo)};
	endfunction

	// simple camera: u = fx*(-y)/x + cx, v = fy*(-z)/x + cy, depth = x
	task automatic set_camera(int f, int cu, int cv);
		write_reg(3'd0, q16_pair(cu <<< 16, (-f) <<< 16));
		write_reg(3'd1, q16_pair(0, 0));
		write_reg(3'd2, q16_pair(cv <<< 16, 0));
		write_reg(3'd3, q16_pair((-f) <<< 16, 0));
		write_reg(3'd4, q16_pair(1 <<< 16, 0));
		write_reg(3'd5, q16_pair(0, 0));
	endtask

	function automatic logic [23:0] rnd_pt();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(8000)) - 4000);
			default: return 24'($urandom_range(12000));
		endcase
	endfunction

	task automatic test_directed();
		set_camera(500, 320, 240);
		send_point(lppc_pkg::ACT_PROJECT, 24'd0, 24'd0, 24'd0);            // behind
		send_point(lppc_pkg::ACT_PROJECT, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
		send_point(lppc_pkg::ACT_PROJECT, 24'd1000, 24'd0, 24'd0);   // empty range: blue
		send_point(lppc_pkg::ACT_MEASURE, 24'd500, 24'd0, 24'd0);
		send_point(lppc_pkg::ACT_PROJECT, 24'd1000, 24'd0, 24'd0);   // single value: blue
		send_point(lppc_pkg::ACT_MEASURE, 24'd4500, 24'd0, 24'd0);
		send_point(lppc_pkg::ACT_MEASURE, 24'hFFF000, 24'd0, 24'd0); // negative ignored
		for (int i = 0; i <= 8; i++)
			send_point(lppc_pkg::ACT_PROJECT, 24'(i*500 + 100), 24'd10, 24'hFFFFF6);
		send_point(lppc_pkg::ACT_PROJECT, 24'd10, 24'h7FFFFF, 24'd0); // off image
		send_point(lppc_pkg::ACT_PROJECT, 24'h7FFFFF, 24'h800000, 24'h800000);
		send_point(2'd3, 24'd100, 24'd0, 24'd0);                      // unused action
		send_point(lppc_pkg::ACT_CLEAR, 24'd0, 24'd0, 24'd0);
		send_point(lppc_pkg::ACT_PROJECT, 24'd2000, 24'd0, 24'd0);
		drain();
		// non-positive depth
		write_reg(3'd4, q16_pair(-(1 <<< 16), 0));
		send_point(lppc_pkg::ACT_PROJECT, 24'd1000, 24'd5, 24'd5);
		drain();
	endtask

	task automatic test_dims();
		logic [12:0] dims [4] = '{13'd0, 13'd1, 13'd4096, 13'h1FFF};
		set_camera(100, 0, 0);
		foreach (dims[i]) begin
			write_reg(lppc_pkg::CFG_WIDTH, 64'(dims[i]));
			write_reg(lppc_pkg::CFG_HEIGHT, 64'(dims[3-i]));
			send_point(lppc_pkg::ACT_PROJECT, 24'd1000, 24'd0, 24'd0);
			send_point(lppc_pkg::ACT_PROJECT, 24'd100, 24'hFFF000, 24'hFFF000);
			send_point(lppc_pkg::ACT_PROJECT, 24'd256, 24'hFF0000, 24'd0);
			drain();
		end
	endtask

	task automatic test_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			if (i % 250 == 0) begin
				drain();
				calm = (i == 500);
				k = $urandom_range(3);
				if (k == 0) begin
					for (int r = 0; r < 6; r++)
						write_reg(3'(r), {$urandom, $urandom});
				end else begin
					set_camera($urandom_range(2000, 50), $urandom_range(1000),
						$urandom_range(1000));
				end
				write_reg(lppc_pkg::CFG_WIDTH, 64'($urandom_range(4200, 1)));
				write_reg(lppc_pkg::CFG_HEIGHT, 64'($urandom_range(4200, 1)));
			end
			k = $urandom_range(99);
			if (k < 3)
				send_point(lppc_pkg::ACT_CLEAR, rnd_pt(), rnd_pt(), rnd_pt());
			else if (k < 30)
				send_point(lppc_pkg::ACT_MEASURE, rnd_pt(), rnd_pt(), rnd_pt());
			else if (k < 32)
				send_point(2'd3, rnd_pt(), rnd_pt(), rnd_pt());
			else
				send_point(lppc_pkg::ACT_PROJECT, rnd_pt(), rnd_pt(), rnd_pt());
		end
		calm = 0;
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cyc       = 0;
		err_cnt   = 0;
		calm      = 0;
		foreach (proj_m[i]) proj_m[i] = '0;
		img_w = 640;
		img_h = 480;
		rng_min = lppc_pkg::RANGE_MIN_RESET;
		rng_max = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_dims();
		test_random(1250);
		if (err_cnt == 0)
			$display("PASS lidar_point_project_colorize_core");
		else
			$display("FAIL lidar_point_project_colorize_core");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/lppc_pkg.sv
hdl/lppc_div.sv
hdl/lidar_point_project_colorize_core.sv
hdl/lppc_chk.sv
tb/sv/lidar_point_project_colorize_core_tb.sv
